// ===== rtl/imt_pkg.sv =====
// ----------------------------------------------------------------------------
// IRC tokenizer package
// Shared types, field tags, parser phases and the built-in command table.
// ----------------------------------------------------------------------------
package imt_pkg;

    // Field tags carried with every byte result.
    localparam logic [2:0] TAG_DROP     = 3'd0;
    localparam logic [2:0] TAG_SENDER   = 3'd1;
    localparam logic [2:0] TAG_USERHOST = 3'd2;
    localparam logic [2:0] TAG_COMMAND  = 3'd3;
    localparam logic [2:0] TAG_PARAM    = 3'd4;
    localparam logic [2:0] TAG_DATA     = 3'd5;

    // Command table geometry.
    localparam int unsigned CMD_MAX  = 7;
    localparam int unsigned NUM_CMDS = 20;
    localparam logic [4:0]  NO_CMD   = 5'd20;

    // Requirement bits of a table entry.
    localparam logic [2:0] NEED_SENDER = 3'b001;
    localparam logic [2:0] NEED_USER   = 3'b010;
    localparam logic [2:0] NEED_DATA   = 3'b100;

    // Parser phases, one-hot.
    typedef enum logic [10:0] {
        PH_START    = 11'b000_0000_0001,
        PH_PRE_WS   = 11'b000_0000_0010,
        PH_SENDER   = 11'b000_0000_0100,
        PH_USERHOST = 11'b000_0000_1000,
        PH_CMD_WS   = 11'b000_0001_0000,
        PH_CMD      = 11'b000_0010_0000,
        PH_PARAM_WS = 11'b000_0100_0000,
        PH_PARAM    = 11'b000_1000_0000,
        PH_IGNORE   = 11'b001_0000_0000,
        PH_DATA     = 11'b010_0000_0000,
        PH_DONE     = 11'b100_0000_0000
    } phase_t;

    // One command entry; text is left-justified, first character in the top byte.
    typedef struct packed {
        logic [8*CMD_MAX-1:0] text;
        logic [2:0]           len;
        logic [2:0]           need;
        logic [1:0]           count;
    } cmd_entry_t;

    localparam cmd_entry_t CMD_TABLE [NUM_CMDS] = '{
        '{"PRIVMSG",          3'd7, NEED_USER | NEED_DATA,   2'd1},
        '{{"PONG", 24'h0},    3'd4, NEED_SENDER | NEED_DATA, 2'd0},
        '{{"PING", 24'h0},    3'd4, NEED_DATA,               2'd0},
        '{{"JOIN", 24'h0},    3'd4, NEED_USER,               2'd0},
        '{{"PART", 24'h0},    3'd4, NEED_USER,               2'd1},
        '{{"QUIT", 24'h0},    3'd4, NEED_USER,               2'd0},
        '{{"MODE", 24'h0},    3'd4, NEED_USER,               2'd1},
        '{{"TOPIC", 16'h0},   3'd5, NEED_USER,               2'd1},
        '{{"NOTICE", 8'h0},   3'd6, NEED_DATA,               2'd1},
        '{{"NICK", 24'h0},    3'd4, NEED_USER | NEED_DATA,   2'd0},
        '{{"KICK", 24'h0},    3'd4, NEED_USER,               2'd2},
        '{{"ERROR", 16'h0},   3'd5, NEED_DATA,               2'd0},
        '{{"KILL", 24'h0},    3'd4, NEED_USER | NEED_DATA,   2'd1},
        '{{"433", 32'h0},     3'd3, NEED_SENDER | NEED_DATA, 2'd2},
        '{{"432", 32'h0},     3'd3, NEED_SENDER | NEED_DATA, 2'd2},
        '{{"421", 32'h0},     3'd3, NEED_SENDER | NEED_DATA, 2'd2},
        '{{"353", 32'h0},     3'd3, NEED_SENDER,             2'd3},
        '{{"332", 32'h0},     3'd3, NEED_SENDER,             2'd2},
        '{{"331", 32'h0},     3'd3, NEED_SENDER,             2'd2},
        '{{"001", 32'h0},     3'd3, NEED_SENDER,             2'd0}
    };

    // What the command matcher needs to know about the finished line.
    typedef struct packed {
        logic [8*CMD_MAX-1:0] cmd_text;
        logic [3:0]           cmd_len;
        logic                 has_sender;
        logic                 has_userhost;
        logic                 has_trailing;
        logic [3:0]           param_cnt;
    } line_info_t;

    // Matcher verdict.
    typedef struct packed {
        logic [4:0] code;
        logic       ok;
    } cmd_result_t;

    // One result item as held in the output register.
    typedef struct packed {
        logic       is_summary;
        logic [2:0] field_tag;
        logic [3:0] param_index;
        logic [7:0] char_out;
        logic       token_start;
        logic [4:0] command_code;
        logic       requirements_met;
        logic       has_sender;
        logic       has_userhost;
        logic       has_trailing;
        logic [3:0] param_total;
    } result_t;

endpackage

// ===== rtl/imt_cmd_match.sv =====
// ----------------------------------------------------------------------------
// IRC command matcher
// Compares the collected command text against every table entry in parallel
// and checks the matched entry's sender, user, data and count needs.
// ----------------------------------------------------------------------------
module imt_cmd_match
    import imt_pkg::*;
(
    input  line_info_t  info,
    output cmd_result_t result
);

    logic       hit;
    logic       len_ok;
    logic [2:0] need;
    logic [1:0] count;
    logic       found;

    // Exact-match search; lower table index wins.
    always_comb
    begin
        len_ok = (info.cmd_len >= 4'd1) && (info.cmd_len <= 4'(CMD_MAX));
        result.code = NO_CMD;
        need = '0;
        count = '0;
        found = 1'b0;
        for (int i = NUM_CMDS - 1; i >= 0; i--)
        begin
            hit = len_ok && (info.cmd_len == {1'b0, CMD_TABLE[i].len});
            for (int j = 0; j < CMD_MAX; j++)
            begin
                if ((4'(j) < info.cmd_len) &&
                    (info.cmd_text[8*(CMD_MAX-1-j) +: 8] !=
                     CMD_TABLE[i].text[8*(CMD_MAX-1-j) +: 8]))
                begin
                    hit = 1'b0;
                end
            end
            if (hit)
            begin
                result.code = 5'(i);
                need = CMD_TABLE[i].need;
                count = CMD_TABLE[i].count;
                found = 1'b1;
            end
        end

        // Requirement check for the matched entry.
        result.ok = found;
        if (((need & NEED_SENDER) != '0) && !info.has_sender)
        begin
            result.ok = 1'b0;
        end
        if (((need & NEED_USER) != '0) && !(info.has_sender && info.has_userhost))
        begin
            result.ok = 1'b0;
        end
        if (((need & NEED_DATA) != '0) && !info.has_trailing)
        begin
            result.ok = 1'b0;
        end
        if (info.param_cnt < {2'b00, count})
        begin
            result.ok = 1'b0;
        end
    end

endmodule

// ===== rtl/irc_message_tokenizer.sv =====
// ----------------------------------------------------------------------------
// IRC message tokenizer
// Tags each byte of an IRC line by field and summarizes the line at its end.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake            | Payload
//  --------+----------------------+-----------------------------------------
//  input   | in_valid / in_stall  | char_in, end_of_line
//  output  | out_valid / out_stall| is_summary .. param_total (one request)
//
//  One request is accepted per cycle unless in_stall is high; each yields
//  exactly one result request. A request passes through an input register,
//  then the parse and command match logic, then the result register.
//  Reset returns the parser to the start of a line and empties both registers.
//  A stalled output holds the result register; in_stall rises only while the
//  input register is full and the result register cannot move.
//
module irc_message_tokenizer
    import imt_pkg::*;
#(
    parameter int unsigned PARAM_LIMIT = 15
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_in,
    input  logic       end_of_line,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       is_summary,
    output logic [2:0] field_tag,
    output logic [3:0] param_index,
    output logic [7:0] char_out,
    output logic       token_start,
    output logic [4:0] command_code,
    output logic       requirements_met,
    output logic       has_sender,
    output logic       has_userhost,
    output logic       has_trailing,
    output logic [3:0] param_total
);

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [3:0] LIMIT    = 4'(PARAM_LIMIT);

    // Whitespace: space, tab, newline, vertical tab, form feed, carriage return.
    function automatic logic is_ws(input logic [7:0] b);
        return (b == 8'd32) || ((b >= 8'd9) && (b <= 8'd13));
    endfunction

    logic        in_valid_reg;
    logic [7:0]  in_char_reg;
    logic        in_eol_reg;
    logic        out_valid_reg;
    result_t     res_reg;
    result_t     res_next;

    phase_t      phase_reg;
    phase_t      phase_next;
    phase_t      eff_phase;
    logic [3:0]  cmd_len_reg;
    logic [3:0]  cmd_len_next;
    logic [3:0]  param_cnt_reg;
    logic [3:0]  param_cnt_next;
    logic [2:0]  flags_reg;
    logic [2:0]  flags_next;
    logic        bang_reg;
    logic        bang_next;
    logic        cmd_we;
    logic [7:0]  cmd_chars_reg [CMD_MAX];

    logic        advance;
    logic        fire;
    logic        has_u;
    line_info_t  info;
    cmd_result_t match;

    // Pipeline control: the result register moves when empty or taken.
    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_char_reg <= char_in;
            in_eol_reg  <= end_of_line;
        end
    end

    // Summary inputs for the command matcher.
    assign has_u = bang_reg ? flags_reg[1] : flags_reg[0];

    always_comb
    begin
        for (int i = 0; i < CMD_MAX; i++)
        begin
            info.cmd_text[8*(CMD_MAX-1-i) +: 8] = cmd_chars_reg[i];
        end
        info.cmd_len      = cmd_len_reg;
        info.has_sender   = flags_reg[0];
        info.has_userhost = has_u;
        info.has_trailing = flags_reg[2];
        info.param_cnt    = param_cnt_reg;
    end

    imt_cmd_match u_match
    (
        .info   (info),
        .result (match)
    );

    // Parser step: one byte or one end-of-line request.
    always_comb
    begin
        phase_next     = phase_reg;
        cmd_len_next   = cmd_len_reg;
        param_cnt_next = param_cnt_reg;
        flags_next     = flags_reg;
        bang_next      = bang_reg;
        cmd_we         = 1'b0;
        eff_phase      = (phase_reg == PH_START) ? PH_CMD_WS : phase_reg;
        res_next              = '0;
        res_next.command_code = NO_CMD;
        res_next.char_out     = in_char_reg;

        if (in_eol_reg)
        begin
            // Summary of the line, then back to the start of a line.
            res_next.is_summary       = 1'b1;
            res_next.char_out         = 8'd0;
            res_next.command_code     = match.code;
            res_next.requirements_met = match.ok;
            res_next.has_sender       = flags_reg[0];
            res_next.has_userhost     = has_u;
            res_next.has_trailing     = flags_reg[2];
            res_next.param_total      = param_cnt_reg;
            phase_next     = PH_START;
            cmd_len_next   = '0;
            param_cnt_next = '0;
            flags_next     = '0;
            bang_next      = 1'b0;
        end
        else if (in_char_reg == 8'd0)
        begin
            // A zero byte ends the text; the rest of the line is dropped.
            phase_next = PH_DONE;
        end
        else if ((phase_reg == PH_START) && (in_char_reg == CH_COLON))
        begin
            phase_next = PH_PRE_WS;
        end
        else
        begin
            unique case (eff_phase) inside
                PH_PRE_WS:
                begin
                    if (is_ws(in_char_reg))
                    begin
                        phase_next = PH_PRE_WS;
                    end
                    else if (in_char_reg == CH_BANG)
                    begin
                        bang_next  = 1'b1;
                        phase_next = PH_USERHOST;
                    end
                    else
                    begin
                        res_next.field_tag   = TAG_SENDER;
                        res_next.token_start = 1'b1;
                        flags_next[0]        = 1'b1;
                        phase_next           = PH_SENDER;
                    end
                end
                PH_SENDER:
                begin
                    if (is_ws(in_char_reg))
                    begin
                        phase_next = PH_CMD_WS;
                    end
                    else if (in_char_reg == CH_BANG)
                    begin
                        bang_next  = 1'b1;
                        phase_next = PH_USERHOST;
                    end
                    else
                    begin
                        res_next.field_tag = TAG_SENDER;
                    end
                end
                PH_USERHOST:
                begin
                    if (is_ws(in_char_reg))
                    begin
                        phase_next = PH_CMD_WS;
                    end
                    else
                    begin
                        res_next.field_tag   = TAG_USERHOST;
                        res_next.token_start = !flags_reg[1];
                        flags_next[1]        = 1'b1;
                    end
                end
                PH_CMD_WS, PH_CMD:
                begin
                    if (is_ws(in_char_reg))
                    begin
                        phase_next = (eff_phase == PH_CMD) ? PH_PARAM_WS : PH_CMD_WS;
                    end
                    else
                    begin
                        res_next.field_tag   = TAG_COMMAND;
                        res_next.token_start = (cmd_len_reg == 4'd0);
                        cmd_we               = (cmd_len_reg < 4'(CMD_MAX));
                        if (cmd_len_reg < 4'(CMD_MAX + 1))
                        begin
                            cmd_len_next = cmd_len_reg + 4'd1;
                        end
                        phase_next = PH_CMD;
                    end
                end
                PH_PARAM_WS:
                begin
                    if (is_ws(in_char_reg))
                    begin
                        phase_next = PH_PARAM_WS;
                    end
                    else if (in_char_reg == CH_COLON)
                    begin
                        phase_next = PH_DATA;
                    end
                    else if (param_cnt_reg < LIMIT)
                    begin
                        res_next.field_tag   = TAG_PARAM;
                        res_next.param_index = param_cnt_reg;
                        res_next.token_start = 1'b1;
                        param_cnt_next       = param_cnt_reg + 4'd1;
                        phase_next           = PH_PARAM;
                    end
                    else
                    begin
                        phase_next = PH_IGNORE;
                    end
                end
                PH_PARAM:
                begin
                    if (is_ws(in_char_reg))
                    begin
                        phase_next = PH_PARAM_WS;
                    end
                    else
                    begin
                        res_next.field_tag   = TAG_PARAM;
                        res_next.param_index = param_cnt_reg - 4'd1;
                    end
                end
                PH_IGNORE:
                begin
                    if (in_char_reg == CH_COLON)
                    begin
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    res_next.field_tag   = TAG_DATA;
                    res_next.token_start = !flags_reg[2];
                    flags_next[2]        = 1'b1;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // Parser state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            cmd_len_reg   <= '0;
            param_cnt_reg <= '0;
            flags_reg     <= '0;
            bang_reg      <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg     <= phase_next;
            cmd_len_reg   <= cmd_len_next;
            param_cnt_reg <= param_cnt_next;
            flags_reg     <= flags_next;
            bang_reg      <= bang_next;
        end
    end

    // Command text; only the first cmd_len bytes are ever compared.
    always_ff @(posedge clk)
    begin
        if (fire && cmd_we)
        begin
            cmd_chars_reg[cmd_len_reg[2:0]] <= in_char_reg;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    // Output ports.
    assign out_valid        = out_valid_reg;
    assign is_summary       = res_reg.is_summary;
    assign field_tag        = res_reg.field_tag;
    assign param_index      = res_reg.param_index;
    assign char_out         = res_reg.char_out;
    assign token_start      = res_reg.token_start;
    assign command_code     = res_reg.command_code;
    assign requirements_met = res_reg.requirements_met;
    assign has_sender       = res_reg.has_sender;
    assign has_userhost     = res_reg.has_userhost;
    assign has_trailing     = res_reg.has_trailing;
    assign param_total      = res_reg.param_total;

    // A summary leaves the parser at the start of a line.
    a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_eol_reg) |=> (phase_reg == PH_START) && (cmd_len_reg == 4'd0))
        else $error("parser state not cleared after end of line");

    // Byte results never carry a recognized command.
    a_byte_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !is_summary) |-> (command_code == NO_CMD) && !requirements_met)
        else $error("byte result carries a command code");

    // Requirements can only be met by a recognized command.
    a_ok_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && requirements_met) |-> (command_code != NO_CMD))
        else $error("requirements met without a matched command");

    // Parameter index appears only on parameter bytes.
    a_param_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (field_tag != TAG_PARAM)) |-> (param_index == 4'd0))
        else $error("parameter index on a non-parameter byte");

endmodule

// ===== tb/irc_token_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IRC tokenizer result checker
// Follows every accepted input request with its own line parser, queues the
// result it predicts, and compares each accepted result request, field by
// field, with the oldest prediction.
// ----------------------------------------------------------------------------
module irc_token_checker
    import imt_pkg::*;
#(
    parameter int unsigned PARAM_LIMIT = 15
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  char_in,
    input  logic        end_of_line,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        is_summary,
    input  logic [2:0]  field_tag,
    input  logic [3:0]  param_index,
    input  logic [7:0]  char_out,
    input  logic        token_start,
    input  logic [4:0]  command_code,
    input  logic        requirements_met,
    input  logic        has_sender,
    input  logic        has_userhost,
    input  logic        has_trailing,
    input  logic [3:0]  param_total,
    output int unsigned error_count,
    output int unsigned results_pending
);

    // One entry of the command list, text left-justified.
    typedef struct packed {
        logic [55:0] text;
        logic [3:0]  len;
        logic [2:0]  need;
        logic [1:0]  count;
    } known_cmd_t;

    // Line parser state of the prediction.
    phase_t      parse_phase;
    logic [7:0]  cmd_chars [7];
    logic [3:0]  cmd_len;
    logic [3:0]  param_cnt;
    logic [2:0]  seen_fields;
    logic        bang_seen;

    result_t     expected_tags [$];
    int unsigned mismatch_total = 0;
    int unsigned result_number = 0;

    // The built-in commands, in table order.
    function automatic known_cmd_t known_cmd(input int idx);
        case (idx)
            0:       known_cmd = {"PRIVMSG",        4'd7, NEED_USER | NEED_DATA,   2'd1};
            1:       known_cmd = {"PONG", 24'h0,    4'd4, NEED_SENDER | NEED_DATA, 2'd0};
            2:       known_cmd = {"PING", 24'h0,    4'd4, NEED_DATA,               2'd0};
            3:       known_cmd = {"JOIN", 24'h0,    4'd4, NEED_USER,               2'd0};
            4:       known_cmd = {"PART", 24'h0,    4'd4, NEED_USER,               2'd1};
            5:       known_cmd = {"QUIT", 24'h0,    4'd4, NEED_USER,               2'd0};
            6:       known_cmd = {"MODE", 24'h0,    4'd4, NEED_USER,               2'd1};
            7:       known_cmd = {"TOPIC", 16'h0,   4'd5, NEED_USER,               2'd1};
            8:       known_cmd = {"NOTICE", 8'h0,   4'd6, NEED_DATA,               2'd1};
            9:       known_cmd = {"NICK", 24'h0,    4'd4, NEED_USER | NEED_DATA,   2'd0};
            10:      known_cmd = {"KICK", 24'h0,    4'd4, NEED_USER,               2'd2};
            11:      known_cmd = {"ERROR", 16'h0,   4'd5, NEED_DATA,               2'd0};
            12:      known_cmd = {"KILL", 24'h0,    4'd4, NEED_USER | NEED_DATA,   2'd1};
            13:      known_cmd = {"433", 32'h0,     4'd3, NEED_SENDER | NEED_DATA, 2'd2};
            14:      known_cmd = {"432", 32'h0,     4'd3, NEED_SENDER | NEED_DATA, 2'd2};
            15:      known_cmd = {"421", 32'h0,     4'd3, NEED_SENDER | NEED_DATA, 2'd2};
            16:      known_cmd = {"353", 32'h0,     4'd3, NEED_SENDER,             2'd3};
            17:      known_cmd = {"332", 32'h0,     4'd3, NEED_SENDER,             2'd2};
            18:      known_cmd = {"331", 32'h0,     4'd3, NEED_SENDER,             2'd2};
            19:      known_cmd = {"001", 32'h0,     4'd3, NEED_SENDER,             2'd0};
            default: known_cmd = '0;
        endcase
    endfunction

    function automatic logic is_ws(input logic [7:0] b);
        is_ws = (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
    endfunction

    // Return the parser to the start of a line.
    task automatic clear_line();
        parse_phase = PH_START;
        for (int k = 0; k < 7; k++)
            cmd_chars[k] = 8'h00;
        cmd_len     = 4'd0;
        param_cnt   = 4'd0;
        seen_fields = 3'b000;
        bang_seen   = 1'b0;
    endtask

    // Work out the result of one request and advance the parser state.
    task automatic tokenize_byte(input logic [7:0] b, input logic eol, output result_t r);
        logic       hs;
        logic       hu;
        logic       hd;
        logic       ok;
        logic       same;
        logic [4:0] code;
        known_cmd_t e;
        r = '0;
        if (eol)
        begin
            // Summary: look the command up and check what it needs.
            hs   = seen_fields[0];
            hu   = bang_seen ? seen_fields[1] : hs;
            hd   = seen_fields[2];
            code = NO_CMD;
            ok   = 1'b0;
            if (cmd_len >= 4'd1 && cmd_len <= 4'd7)
            begin
                for (int i = 0; i < 20; i++)
                begin
                    e    = known_cmd(i);
                    same = (e.len == cmd_len);
                    for (int k = 0; k < 7; k++)
                        if (k < cmd_len && cmd_chars[k] != e.text[55 - 8 * k -: 8])
                            same = 1'b0;
                    if (same && code == NO_CMD)
                        code = 5'(i);
                end
            end
            if (code != NO_CMD)
            begin
                e  = known_cmd(int'(code));
                ok = 1'b1;
                if ((e.need & NEED_SENDER) != 0 && !hs)
                    ok = 1'b0;
                if ((e.need & NEED_USER) != 0 && !(hs && hu))
                    ok = 1'b0;
                if ((e.need & NEED_DATA) != 0 && !hd)
                    ok = 1'b0;
                if (param_cnt < {2'b00, e.count})
                    ok = 1'b0;
            end
            r.is_summary       = 1'b1;
            r.command_code     = code;
            r.requirements_met = ok;
            r.has_sender       = hs;
            r.has_userhost     = hu;
            r.has_trailing     = hd;
            r.param_total      = param_cnt;
            clear_line();
        end
        else
        begin
            r.char_out     = b;
            r.command_code = NO_CMD;
            if (b == 8'h00)
                parse_phase = PH_DONE;
            else if (parse_phase == PH_START && b == ":")
                parse_phase = PH_PRE_WS;
            else
            begin
                if (parse_phase == PH_START)
                    parse_phase = PH_CMD_WS;
                case (parse_phase) inside
                    PH_PRE_WS:
                    begin
                        if (!is_ws(b))
                        begin
                            if (b == "!")
                            begin
                                bang_seen   = 1'b1;
                                parse_phase = PH_USERHOST;
                            end
                            else
                            begin
                                r.field_tag    = TAG_SENDER;
                                r.token_start  = 1'b1;
                                seen_fields[0] = 1'b1;
                                parse_phase    = PH_SENDER;
                            end
                        end
                    end
                    PH_SENDER:
                    begin
                        if (is_ws(b))
                            parse_phase = PH_CMD_WS;
                        else if (b == "!")
                        begin
                            bang_seen   = 1'b1;
                            parse_phase = PH_USERHOST;
                        end
                        else
                            r.field_tag = TAG_SENDER;
                    end
                    PH_USERHOST:
                    begin
                        if (is_ws(b))
                            parse_phase = PH_CMD_WS;
                        else
                        begin
                            r.field_tag    = TAG_USERHOST;
                            r.token_start  = !seen_fields[1];
                            seen_fields[1] = 1'b1;
                        end
                    end
                    PH_CMD_WS, PH_CMD:
                    begin
                        if (is_ws(b))
                        begin
                            if (parse_phase == PH_CMD)
                                parse_phase = PH_PARAM_WS;
                        end
                        else
                        begin
                            // The command keeps seven bytes; its length stops at eight.
                            r.field_tag   = TAG_COMMAND;
                            r.token_start = (cmd_len == 4'd0);
                            if (cmd_len < 4'd7)
                                cmd_chars[cmd_len[2:0]] = b;
                            if (cmd_len < 4'd8)
                                cmd_len = cmd_len + 4'd1;
                            parse_phase = PH_CMD;
                        end
                    end
                    PH_PARAM_WS:
                    begin
                        if (!is_ws(b))
                        begin
                            if (b == ":")
                                parse_phase = PH_DATA;
                            else if (param_cnt < PARAM_LIMIT)
                            begin
                                r.field_tag   = TAG_PARAM;
                                r.param_index = param_cnt;
                                r.token_start = 1'b1;
                                param_cnt     = param_cnt + 4'd1;
                                parse_phase   = PH_PARAM;
                            end
                            else
                                parse_phase = PH_IGNORE;
                        end
                    end
                    PH_PARAM:
                    begin
                        if (is_ws(b))
                            parse_phase = PH_PARAM_WS;
                        else
                        begin
                            r.field_tag   = TAG_PARAM;
                            r.param_index = param_cnt - 4'd1;
                        end
                    end
                    PH_IGNORE:
                    begin
                        if (b == ":")
                            parse_phase = PH_DATA;
                    end
                    PH_DATA:
                    begin
                        r.field_tag    = TAG_DATA;
                        r.token_start  = !seen_fields[2];
                        seen_fields[2] = 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    endtask

    // Print one line for a mismatch and count it.
    task automatic report_mismatch(input string msg);
        mismatch_total++;
        $display("[%0t] result %0d: %s", $time, result_number, msg);
    endtask

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    // Results are checked before the request of the same edge is predicted.
    always @(posedge clk)
    begin
        result_t want;
        result_t predicted;
        if (!rst_n)
        begin
            clear_line();
            expected_tags.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_tags.size() == 0)
                    report_mismatch("result with no request outstanding");
                else
                begin
                    want = expected_tags.pop_front();
                    compare_field("is_summary", 8'(is_summary), 8'(want.is_summary));
                    compare_field("field_tag", 8'(field_tag), 8'(want.field_tag));
                    compare_field("param_index", 8'(param_index), 8'(want.param_index));
                    compare_field("char_out", char_out, want.char_out);
                    compare_field("token_start", 8'(token_start), 8'(want.token_start));
                    compare_field("command_code", 8'(command_code), 8'(want.command_code));
                    compare_field("requirements_met", 8'(requirements_met),
                                  8'(want.requirements_met));
                    compare_field("has_sender", 8'(has_sender), 8'(want.has_sender));
                    compare_field("has_userhost", 8'(has_userhost), 8'(want.has_userhost));
                    compare_field("has_trailing", 8'(has_trailing), 8'(want.has_trailing));
                    compare_field("param_total", 8'(param_total), 8'(want.param_total));
                end
                result_number++;
            end
            if (in_valid && !in_stall)
            begin
                tokenize_byte(char_in, end_of_line, predicted);
                expected_tags.push_back(predicted);
            end
        end
        results_pending <= expected_tags.size();
        error_count     <= mismatch_total;
    end

endmodule

// ===== tb/tb_irc_message_tokenizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IRC message tokenizer testbench
// Sends a few hand-written lines and then random IRC lines, well-formed for
// the most part, with random gaps on both channels and one long output stall.
// The checker predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_irc_message_tokenizer;

    localparam int unsigned PARAM_LIMIT  = 15;
    localparam int unsigned RANDOM_ITEMS = 1850;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned HOLD_AFTER   = 600;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 20;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [7:0]  char_in     = 8'h00;
    logic        end_of_line = 1'b0;
    logic        out_valid;
    logic        out_stall;
    logic        is_summary;
    logic [2:0]  field_tag;
    logic [3:0]  param_index;
    logic [7:0]  char_out;
    logic        token_start;
    logic [4:0]  command_code;
    logic        requirements_met;
    logic        has_sender;
    logic        has_userhost;
    logic        has_trailing;
    logic [3:0]  param_total;
    int unsigned error_count;
    int unsigned results_pending;

    logic        rx_stall    = 1'b0;
    logic        long_hold   = 1'b0;
    logic        line_no_gaps = 1'b0;
    int unsigned items_sent  = 0;
    int unsigned cycle_count = 0;

    assign out_stall = rx_stall | long_hold;

    irc_message_tokenizer #(.PARAM_LIMIT(PARAM_LIMIT)) u_top (.*);

    irc_token_checker #(.PARAM_LIMIT(PARAM_LIMIT)) u_checker (.*);

    always
    begin
        #4 clk = ~clk;
    end

    // Give up on a run that hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic string cmd_name(input int idx);
        case (idx)
            0:       cmd_name = "PRIVMSG";
            1:       cmd_name = "PONG";
            2:       cmd_name = "PING";
            3:       cmd_name = "JOIN";
            4:       cmd_name = "PART";
            5:       cmd_name = "QUIT";
            6:       cmd_name = "MODE";
            7:       cmd_name = "TOPIC";
            8:       cmd_name = "NOTICE";
            9:       cmd_name = "NICK";
            10:      cmd_name = "KICK";
            11:      cmd_name = "ERROR";
            12:      cmd_name = "KILL";
            13:      cmd_name = "433";
            14:      cmd_name = "432";
            15:      cmd_name = "421";
            16:      cmd_name = "353";
            17:      cmd_name = "332";
            18:      cmd_name = "331";
            default: cmd_name = "001";
        endcase
    endfunction

    function automatic logic [7:0] ws_char();
        int unsigned idx;
        idx = $urandom_range(0, 5);
        ws_char = (idx == 0) ? 8'd32 : 8'(8 + idx);
    endfunction

    // Any non-blank byte but the colon.
    function automatic logic [7:0] word_char();
        logic [7:0] c;
        c = 8'($urandom_range(33, 255));
        word_char = (c == ":") ? 8'h7E : c;
    endfunction

    // Offer one request after a random gap and wait until it is taken.
    task automatic send_item(input logic [7:0] c, input logic eol);
        int unsigned gap;
        gap = line_no_gaps ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        char_in     <= c;
        end_of_line <= eol;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    task automatic send_eol();
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    task automatic send_word(input int unsigned n);
        repeat (n) send_item(word_char(), 1'b0);
    endtask

    // One random line: mostly prefix, command, parameters and trailing data.
    task automatic send_random_line();
        int unsigned kind;
        int unsigned n;
        int unsigned pick;
        line_no_gaps = ($urandom_range(0, 3) == 0);
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            // Noise line of arbitrary bytes.
            n = $urandom_range(1, 12);
            repeat (n) send_item(8'($urandom_range(0, 255)), 1'b0);
        end
        else
        begin
            // Optional prefix, with or without a user part.
            if ($urandom_range(0, 2) != 0)
            begin
                send_item(":", 1'b0);
                if ($urandom_range(0, 4) == 0)
                    send_item(ws_char(), 1'b0);
                send_word($urandom_range(0, 6));
                if ($urandom_range(0, 1) == 1)
                begin
                    send_item("!", 1'b0);
                    send_word($urandom_range(0, 8));
                end
                send_item(ws_char(), 1'b0);
            end
            else if ($urandom_range(0, 5) == 0)
                send_item(ws_char(), 1'b0);

            // Known command, unknown short word or overlong word.
            pick = $urandom_range(0, 9);
            if (pick < 6)
                send_text(cmd_name($urandom_range(0, 19)));
            else if (pick < 8)
                send_word($urandom_range(1, 7));
            else
                send_word($urandom_range(8, 11));

            // Parameters, now and then past the limit.
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 18) : $urandom_range(0, 4);
            repeat (n)
            begin
                repeat ($urandom_range(1, 2)) send_item(ws_char(), 1'b0);
                send_word($urandom_range(1, 4));
            end

            // Trailing data, blanks and colons included.
            if ($urandom_range(0, 1) == 1)
            begin
                send_item(ws_char(), 1'b0);
                send_item(":", 1'b0);
                repeat ($urandom_range(0, 8))
                begin
                    pick = $urandom_range(0, 5);
                    if (pick == 0)
                        send_item(ws_char(), 1'b0);
                    else if (pick == 1)
                        send_item(":", 1'b0);
                    else
                        send_item(word_char(), 1'b0);
                end
            end

            // A zero byte cuts the rest of the line off.
            if ($urandom_range(0, 11) == 0)
            begin
                send_item(8'h00, 1'b0);
                repeat ($urandom_range(0, 3)) send_item(8'($urandom_range(0, 255)), 1'b0);
            end
        end
        send_eol();
    endtask

    // Output side: a random stall before every result, with quiet stretches.
    initial
    begin : result_sink
        int unsigned wait_cycles;
        int unsigned quiet_left;
        quiet_left = 0;
        forever
        begin
            if (quiet_left > 0)
            begin
                wait_cycles = 0;
                quiet_left--;
            end
            else
            begin
                wait_cycles = $urandom_range(0, 15);
                if ($urandom_range(0, 15) == 0)
                    quiet_left = $urandom_range(20, 80);
            end
            if (wait_cycles > 0)
            begin
                rx_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            rx_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    // One long output stall while requests keep coming, so the block fills up.
    initial
    begin
        wait (items_sent >= HOLD_AFTER);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
    end

    // Reset, stimulus, drain and verdict.
    initial
    begin
        int unsigned directed_items;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Empty line.
        send_eol();
        // Prefix split at the bang, separators, one parameter, trailing data.
        send_text(":n!u P x :t");
        send_eol();
        // Top byte value, then a zero byte that drops the rest of the line.
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b0);
        send_item("A", 1'b0);
        send_eol();
        // Command too long to match.
        send_text("NICKNAMES");
        send_eol();

        directed_items = items_sent;
        while (items_sent < directed_items + RANDOM_ITEMS)
            send_random_line();
        in_valid <= 1'b0;

        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/imt_pkg.sv
rtl/imt_cmd_match.sv
rtl/irc_message_tokenizer.sv
tb/irc_token_checker.sv
tb/tb_irc_message_tokenizer.sv
